### hw/rtl/rlms_pkg.sv
// Package for the RGB LED mode sequencer: request and result types,
// command and mode codes, register indexes and the colour decode helper.
// No dependencies.
package rlms_pkg;

  // Command codes carried in a request.
  localparam logic [2:0] CMD_MS_TICK    = 3'd0;
  localparam logic [2:0] CMD_PWM_TICK   = 3'd1;
  localparam logic [2:0] CMD_SET_MODE   = 3'd2;
  localparam logic [2:0] CMD_NEXT_SOLID = 3'd3;
  localparam logic [2:0] CMD_DIRECT_SET = 3'd4;

  // Mode codes.
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_SOLID   = 3'd1;
  localparam logic [2:0] MODE_CYCLE   = 3'd2;
  localparam logic [2:0] MODE_BLINK_R = 3'd3;
  localparam logic [2:0] MODE_BLINK_G = 3'd4;
  localparam logic [2:0] MODE_BLINK_B = 3'd5;
  localparam logic [2:0] MODE_BREATHE = 3'd6;

  // Reset values of the state and configuration.
  localparam logic [2:0]  MODE_RESET          = MODE_CYCLE;
  localparam logic [15:0] CYCLE_STEP_MS_RESET = 16'd333;
  localparam logic [15:0] BLINK_HALF_MS_RESET = 16'd250;

  // Configuration register indexes (paddr bit 2).
  localparam logic REG_CYCLE_STEP = 1'b0;
  localparam logic REG_BLINK_HALF = 1'b1;

  // LED level bits: bit 0 red, bit 1 green, bit 2 blue.
  localparam logic [2:0] LV_NONE = 3'b000;
  localparam logic [2:0] LV_R    = 3'b001;
  localparam logic [2:0] LV_G    = 3'b010;
  localparam logic [2:0] LV_B    = 3'b100;
  localparam logic [2:0] LV_ALL  = 3'b111;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] now_ms;
    logic [2:0]  mode_value;
    logic        red_in;
    logic        green_in;
    logic        blue_in;
  } req_item_t;

  typedef struct packed {
    logic       red_on;
    logic       green_on;
    logic       blue_on;
    logic       updated;
    logic [2:0] current_mode;
  } rsp_item_t;

  typedef struct packed {
    logic [15:0] cycle_step_ms;
    logic [15:0] blink_half_ms;
  } cfg_t;

  function automatic logic [2:0] one_hot(input logic [1:0] idx);
    logic [2:0] lv;
    case (idx)
      2'd0:    lv = LV_R;
      2'd1:    lv = LV_G;
      2'd2:    lv = LV_B;
      default: lv = LV_NONE;
    endcase
    return lv;
  endfunction

endpackage

### hw/rtl/rlms_regs.sv
// Configuration registers of the RGB LED mode sequencer behind an APB-style port.
// Depends on rlms_pkg.
module rlms_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output rlms_pkg::cfg_t       cfg
);
  import rlms_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cycle_step_ms <= CYCLE_STEP_MS_RESET;
      cfg.blink_half_ms <= BLINK_HALF_MS_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_CYCLE_STEP: cfg.cycle_step_ms <= pwdata[15:0];
        REG_BLINK_HALF: cfg.blink_half_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CYCLE_STEP: prdata = {16'd0, cfg.cycle_step_ms};
      REG_BLINK_HALF: prdata = {16'd0, cfg.blink_half_ms};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

### hw/rtl/rlms_core.sv
// Sequencer state and the single-pass update for one request.
// Depends on rlms_pkg.
module rlms_core #(
  parameter int PWM_PERIOD = 32,
  parameter int MAX_LEVEL  = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  rlms_pkg::req_item_t  item,
  input  rlms_pkg::cfg_t       cfg,
  output rlms_pkg::rsp_item_t  result
);
  import rlms_pkg::*;

  localparam int CW = (PWM_PERIOD > 1) ? $clog2(PWM_PERIOD) : 1;
  localparam int LW = $clog2(MAX_LEVEL + 1);
  localparam int MW = (CW > LW) ? CW : LW;

  logic [2:0]    mode_reg,       mode_reg_next;
  logic [1:0]    solid_index,    solid_index_next;
  logic [31:0]   last_step_time, last_step_time_next;
  logic [1:0]    phase,          phase_next;
  logic [CW-1:0] pwm_count,      pwm_count_next;
  logic [LW-1:0] bright_level,   bright_level_next;
  logic          rising,         rising_next;
  logic [2:0]    led_levels,     led_levels_next;
  logic          upd;

  logic          is_blink;
  logic [15:0]   period;
  logic [31:0]   elapsed;
  logic [1:0]    blink_sel;
  logic [CW:0]   pwm_inc;

  assign is_blink  = (mode_reg inside {[MODE_BLINK_R:MODE_BLINK_B]});
  assign period    = (mode_reg == MODE_CYCLE) ? cfg.cycle_step_ms : cfg.blink_half_ms;
  assign elapsed   = item.now_ms - last_step_time;
  assign blink_sel = 2'(mode_reg - MODE_BLINK_R);
  assign pwm_inc   = {1'b0, pwm_count} + (CW + 1)'(1);

  always_comb begin
    mode_reg_next       = mode_reg;
    solid_index_next    = solid_index;
    last_step_time_next = last_step_time;
    phase_next          = phase;
    pwm_count_next      = pwm_count;
    bright_level_next   = bright_level;
    rising_next         = rising;
    led_levels_next     = led_levels;
    upd                 = 1'b0;

    case (item.command)
      CMD_MS_TICK: begin
        if ((mode_reg == MODE_CYCLE || is_blink) && elapsed >= {16'd0, period}) begin
          last_step_time_next = item.now_ms;
          upd                 = 1'b1;
          if (mode_reg == MODE_CYCLE) begin
            case (phase)
              2'd0:    phase_next = 2'd1;
              2'd1:    phase_next = 2'd2;
              2'd2:    phase_next = 2'd0;
              default: phase_next = 2'd1;
            endcase
            led_levels_next = one_hot(phase_next);
          end else begin
            phase_next      = phase ^ 2'd1;
            led_levels_next = (phase_next != 2'd0) ? one_hot(blink_sel) : LV_NONE;
          end
        end
      end
      CMD_PWM_TICK: begin
        if (mode_reg == MODE_BREATHE) begin
          upd             = 1'b1;
          led_levels_next = (MW'(pwm_count) < MW'(bright_level)) ? LV_ALL : LV_NONE;
          pwm_count_next  = pwm_inc[CW-1:0];
          // End of a PWM period: move the brightness one step along the
          // triangle, holding one extra period at each end.
          if (pwm_inc >= (CW + 1)'(PWM_PERIOD)) begin
            pwm_count_next = '0;
            if (rising) begin
              if (bright_level >= LW'(MAX_LEVEL)) begin
                bright_level_next = LW'(MAX_LEVEL);
                rising_next       = 1'b0;
              end else begin
                bright_level_next = bright_level + LW'(1);
              end
            end else begin
              if (bright_level == '0) begin
                rising_next = 1'b1;
              end else begin
                bright_level_next = bright_level - LW'(1);
              end
            end
          end
        end
      end
      CMD_SET_MODE: begin
        if (item.mode_value <= MODE_BREATHE) begin
          mode_reg_next       = item.mode_value;
          phase_next          = 2'd0;
          last_step_time_next = item.now_ms;
          if (item.mode_value == MODE_OFF) begin
            led_levels_next = LV_NONE;
            upd             = 1'b1;
          end
        end
      end
      CMD_NEXT_SOLID: begin
        solid_index_next = (solid_index >= 2'd2) ? 2'd0 : solid_index + 2'd1;
        mode_reg_next    = MODE_SOLID;
        led_levels_next  = one_hot(solid_index_next);
        upd              = 1'b1;
      end
      CMD_DIRECT_SET: begin
        led_levels_next = {item.blue_in, item.green_in, item.red_in};
        upd             = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= MODE_RESET;
      solid_index    <= 2'd0;
      last_step_time <= 32'd0;
      phase          <= 2'd0;
      pwm_count      <= '0;
      bright_level   <= '0;
      rising         <= 1'b1;
      led_levels     <= LV_NONE;
    end else if (step) begin
      mode_reg       <= mode_reg_next;
      solid_index    <= solid_index_next;
      last_step_time <= last_step_time_next;
      phase          <= phase_next;
      pwm_count      <= pwm_count_next;
      bright_level   <= bright_level_next;
      rising         <= rising_next;
      led_levels     <= led_levels_next;
    end
  end

  assign result.red_on       = led_levels_next[0];
  assign result.green_on     = led_levels_next[1];
  assign result.blue_on      = led_levels_next[2];
  assign result.updated      = upd;
  assign result.current_mode = mode_reg_next;

endmodule

### hw/rtl/rgb_led_mode_sequencer.sv
// RGB LED mode sequencer, top level: request register, update core, result register
// and the configuration port. Depends on rlms_pkg, rlms_regs and rlms_core.
//
// Each request (ms tick, PWM tick, set mode, next solid colour, direct set)
// yields exactly one result carrying the lit state of the three colours, an
// updated flag and the mode after the request. A request is taken every clock
// cycle while results are taken; its result is offered once it has moved
// from the request register into the result register, and can be taken at the
// next edge. The whole state update is one pass of short logic between those
// two registers, so a stalled result only stops intake once both registers are
// full. The outputs are logical "lit" bits; drive the pins with their
// complements. Write the two timing registers (cycle step at 0x0, blink half
// period at 0x4) only while idle.
module rgb_led_mode_sequencer #(
  parameter int PWM_PERIOD = 32,
  parameter int MAX_LEVEL  = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  rlms_pkg::req_item_t  req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rlms_pkg::rsp_item_t  rsp_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rlms_pkg::*;

  logic      held;
  req_item_t held_item;
  logic      advance;
  cfg_t      cfg;
  rsp_item_t result;

  assign advance   = held & (~rsp_valid | rsp_ready);
  assign req_ready = ~held | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_ready) begin
        held <= req_valid;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      held_item <= req_data;
    end
    if (advance) begin
      rsp_data <= result;
    end
  end

  rlms_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlms_core #(
    .PWM_PERIOD (PWM_PERIOD),
    .MAX_LEVEL  (MAX_LEVEL)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (held_item),
    .cfg    (cfg),
    .result (result)
  );

endmodule

### hw/rtl/rlms_checker.sv
// Port-level checks for the RGB LED mode sequencer, bound to the top level.
// Depends on rlms_pkg and rgb_led_mode_sequencer.
module rlms_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input rlms_pkg::rsp_item_t  rsp_data
);
  import rlms_pkg::*;

  // A stalled result keeps its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  // With no result waiting, the block must take requests.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request refused with empty result stage");

  // Every accepted request is followed by a result on offer.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> ##2 rsp_valid)
    else $error("result missing two cycles after a request");

  // The reserved mode code is never reported.
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.current_mode <= MODE_BREATHE)
    else $error("reserved mode reported");

endmodule

bind rgb_led_mode_sequencer rlms_checker u_rlms_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);

### test/rgb_led_mode_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb_led_mode_sequencer: random requests and results
// under valid/ready handshakes, checked against a behavioral LED predictor.
// Depends on rlms_pkg and the rgb_led_mode_sequencer RTL.
module rgb_led_mode_sequencer_test;
  import rlms_pkg::*;

  localparam int PWM_PERIOD = 32;
  localparam int MAX_LEVEL  = 31;

  // Codes the package leaves unnamed.
  localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;
  localparam logic [2:0] MODE_RESERVED      = 3'd7;

  localparam int SETTLE_CYCLES     = 4;
  localparam int LONG_HOLD_CYCLES  = 48;
  localparam int IDLE_PCT_DEFAULT  = 15;
  localparam int BREATHE_SWEEP     = 96;

  logic       clk;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  req_item_t  req_data = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  rsp_item_t  rsp_data;
  logic       psel = 1'b0;
  logic       penable = 1'b0;
  logic       pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic       pready;

  // Predictor state and timing configuration.
  logic [2:0]  mode_q = MODE_RESET;
  int unsigned solid_idx = 0;
  logic [31:0] last_step = '0;
  int unsigned phase_q = 0;
  int unsigned pwm_cnt = 0;
  int unsigned bright = 0;
  bit          rising_q = 1'b1;
  logic [2:0]  levels = LV_NONE;
  logic [15:0] cycle_ms = CYCLE_STEP_MS_RESET;
  logic [15:0] blink_ms = BLINK_HALF_MS_RESET;

  rsp_item_t   pending_led_results[$];
  logic [31:0] clock_ms = '0;
  int          send_idle_pct = IDLE_PCT_DEFAULT;
  int          recv_idle_pct = IDLE_PCT_DEFAULT;
  bit          hold_results = 1'b0;
  int          errors = 0;
  int          requests_sent = 0;
  int          results_checked = 0;
  int          led_rewrites = 0;
  int          input_stalls = 0;
  int          timing_writes = 0;

  rgb_led_mode_sequencer #(
    .PWM_PERIOD(PWM_PERIOD),
    .MAX_LEVEL(MAX_LEVEL)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data(rsp_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Timed out at %0t with %0d results outstanding", $time,
             pending_led_results.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [2:0] lit_colour(input int unsigned idx);
    logic [2:0] lv;
    case (idx)
      0:       lv = LV_R;
      1:       lv = LV_G;
      2:       lv = LV_B;
      default: lv = LV_NONE;
    endcase
    return lv;
  endfunction

  // Applies one request to the predictor state and returns the LED result it causes.
  function automatic rsp_item_t next_led_result(input req_item_t r);
    rsp_item_t   res;
    logic [31:0] period;
    logic [31:0] elapsed;
    logic        upd;
    upd = 1'b0;
    case (r.command)
      CMD_MS_TICK: begin
        if (mode_q == MODE_CYCLE || (mode_q >= MODE_BLINK_R && mode_q <= MODE_BLINK_B)) begin
          period = (mode_q == MODE_CYCLE) ? {16'd0, cycle_ms} : {16'd0, blink_ms};
          elapsed = r.now_ms - last_step;
          if (elapsed >= period) begin
            last_step = r.now_ms;
            upd = 1'b1;
            if (mode_q == MODE_CYCLE) begin
              phase_q = (phase_q + 1) % 3;
              levels = lit_colour(phase_q);
            end else begin
              // Blink phases only toggle between dark and lit.
              phase_q = (phase_q ^ 1) & 3;
              levels = (phase_q != 0) ? lit_colour(mode_q - MODE_BLINK_R) : LV_NONE;
            end
          end
        end
      end
      CMD_PWM_TICK: begin
        if (mode_q == MODE_BREATHE) begin
          levels = (pwm_cnt < bright) ? LV_ALL : LV_NONE;
          pwm_cnt++;
          if (pwm_cnt >= PWM_PERIOD) begin
            pwm_cnt = 0;
            // Each end of the triangle is held for one extra PWM period.
            if (rising_q) begin
              if (bright >= MAX_LEVEL) begin
                bright = MAX_LEVEL;
                rising_q = 1'b0;
              end else begin
                bright++;
              end
            end else if (bright == 0) begin
              rising_q = 1'b1;
            end else begin
              bright--;
            end
          end
          upd = 1'b1;
        end
      end
      CMD_SET_MODE: begin
        if (r.mode_value != MODE_RESERVED) begin
          mode_q = r.mode_value;
          phase_q = 0;
          last_step = r.now_ms;
          if (r.mode_value == MODE_OFF) begin
            levels = LV_NONE;
            upd = 1'b1;
          end
        end
      end
      CMD_NEXT_SOLID: begin
        solid_idx = (solid_idx + 1) % 3;
        mode_q = MODE_SOLID;
        levels = lit_colour(solid_idx);
        upd = 1'b1;
      end
      CMD_DIRECT_SET: begin
        levels = {r.blue_in, r.green_in, r.red_in};
        upd = 1'b1;
      end
      default: ;
    endcase
    res.red_on = levels[0];
    res.green_on = levels[1];
    res.blue_on = levels[2];
    res.updated = upd;
    res.current_mode = mode_q;
    return res;
  endfunction

  function automatic void check_field(input string field, input logic [2:0] want,
                                      input logic [2:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    rsp_item_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_led_results.size() == 0) begin
        errors++;
        $display("%0t: result %b arrived with no request outstanding", $time, rsp_data);
      end else begin
        want = pending_led_results.pop_front();
        check_field("red_on", 3'(want.red_on), 3'(rsp_data.red_on));
        check_field("green_on", 3'(want.green_on), 3'(rsp_data.green_on));
        check_field("blue_on", 3'(want.blue_on), 3'(rsp_data.blue_on));
        check_field("updated", 3'(want.updated), 3'(rsp_data.updated));
        check_field("current_mode", want.current_mode, rsp_data.current_mode);
        results_checked++;
        if (want.updated) led_rewrites++;
      end
    end
  end

  // Result side: random stalls, plus one long hold when a test asks for it.
  initial begin : result_sink
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_results) begin
        rsp_ready <= 1'b0;
        for (n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clk);
        hold_results = 1'b0;
        rsp_ready <= 1'b1;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Valid is left high after acceptance; whoever lets time pass next lowers it or drives a new request.
  task automatic send_request(input req_item_t r);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (!req_ready) begin
      input_stalls++;
      @(posedge clk);
    end
    pending_led_results.push_back(next_led_result(r));
    requests_sent++;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_led_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timing(input logic reg_sel, input logic [15:0] value);
    logic [31:0] word;
    wait_idle();
    word = $urandom;
    word[15:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_CYCLE_STEP) cycle_ms = value;
    else blink_ms = value;
    timing_writes++;
    // Read the register straight back.
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[15:0] !== value) begin
      errors++;
      $display("%0t: readback at %0d, expected %0d, got %0d", $time, {reg_sel, 2'b00},
               value, prdata[15:0]);
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic req_item_t request_of(input logic [2:0] cmd, input logic [31:0] now,
                                           input logic [2:0] mv, input logic [2:0] rgb);
    req_item_t r;
    r.command = cmd;
    r.now_ms = now;
    r.mode_value = mv;
    r.red_in = rgb[0];
    r.green_in = rgb[1];
    r.blue_in = rgb[2];
    return r;
  endfunction

  function automatic req_item_t random_request();
    req_item_t r;
    r.command = 3'($urandom_range(CMD_MS_TICK, CMD_RESERVED_LAST));
    r.now_ms = $urandom;
    r.mode_value = 3'($urandom_range(MODE_OFF, MODE_RESERVED));
    r.red_in = 1'($urandom_range(0, 1));
    r.green_in = 1'($urandom_range(0, 1));
    r.blue_in = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // A mode change followed mostly by the ticks that mode responds to, with some noise.
  task automatic run_episode(input int length);
    req_item_t   r;
    logic [31:0] period;
    logic [31:0] gap;
    int          k;
    int          pick;
    if ($urandom_range(0, 7) == 0)
      clock_ms = ($urandom_range(0, 1) == 0) ? $urandom
                                             : 32'hFFFF_FFFF - $urandom_range(0, 2000);
    r = random_request();
    if ($urandom_range(0, 9) == 0) begin
      r.command = CMD_NEXT_SOLID;
    end else begin
      r.command = CMD_SET_MODE;
      r.now_ms = clock_ms;
      if ($urandom_range(0, 3) != 0)
        r.mode_value = 3'($urandom_range(MODE_CYCLE, MODE_BREATHE));
      else r.mode_value = 3'($urandom_range(MODE_OFF, MODE_BREATHE));
    end
    send_request(r);
    for (k = 0; k < length; k++) begin
      r = random_request();
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        if (mode_q == MODE_BREATHE) begin
          r.command = CMD_PWM_TICK;
        end else begin
          period = (mode_q == MODE_CYCLE) ? {16'd0, cycle_ms} : {16'd0, blink_ms};
          case ($urandom_range(0, 3))
            0:       gap = period - 1;
            1:       gap = period;
            default: gap = $urandom_range(0, 2 * period + 2);
          endcase
          clock_ms += gap;
          r.command = CMD_MS_TICK;
          r.now_ms = clock_ms;
        end
      end else if (pick < 82) begin
        r.command = CMD_DIRECT_SET;
      end else if (pick < 87) begin
        r.command = CMD_NEXT_SOLID;
      end else if (pick < 93) begin
        // Stray tick with an arbitrary timestamp.
        r.command = ($urandom_range(0, 1) == 0) ? CMD_MS_TICK : CMD_PWM_TICK;
      end else if (pick < 97) begin
        r.command = CMD_SET_MODE;
        r.now_ms = clock_ms;
      end else begin
        r.command = 3'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
      end
      send_request(r);
    end
  endtask

  task automatic timing_phase(input logic [15:0] step_ms, input logic [15:0] half_ms,
                              input int items);
    int start;
    write_timing(REG_CYCLE_STEP, step_ms);
    write_timing(REG_BLINK_HALF, half_ms);
    start = requests_sent;
    while (requests_sent - start < items) run_episode($urandom_range(6, 40));
  endtask

  task automatic test_directed_commands();
    send_request(request_of(CMD_MS_TICK, 32'd332, MODE_OFF, LV_NONE));
    send_request(request_of(CMD_MS_TICK, 32'd333, MODE_RESERVED, LV_ALL));
    send_request(request_of(CMD_MS_TICK, 32'hFFFF_FFFF, MODE_OFF, LV_NONE));
    send_request(request_of(CMD_PWM_TICK, 32'hFFFF_FFFF, MODE_BREATHE, LV_ALL));
    send_request(request_of(CMD_RESERVED_FIRST, 32'd0, MODE_OFF, LV_ALL));
    send_request(request_of(CMD_RESERVED_LAST, 32'hFFFF_FFFF, MODE_RESERVED, LV_ALL));
    send_request(request_of(CMD_SET_MODE, 32'd77, MODE_RESERVED, LV_NONE));
    send_request(request_of(CMD_SET_MODE, 32'hFFFF_FFFF, MODE_OFF, LV_ALL));
    send_request(request_of(CMD_MS_TICK, 32'd5000, MODE_OFF, LV_NONE));
    send_request(request_of(CMD_NEXT_SOLID, 32'd0, MODE_OFF, LV_NONE));
    send_request(request_of(CMD_NEXT_SOLID, 32'd0, MODE_OFF, LV_NONE));
    send_request(request_of(CMD_NEXT_SOLID, 32'd0, MODE_OFF, LV_NONE));
    send_request(request_of(CMD_MS_TICK, 32'h8000_0000, MODE_OFF, LV_NONE));
    send_request(request_of(CMD_DIRECT_SET, 32'd0, MODE_OFF, LV_R | LV_B));
    send_request(request_of(CMD_DIRECT_SET, 32'hFFFF_FFFF, MODE_RESERVED, LV_G));
    // Blink red from a timestamp that wraps on the first tick.
    send_request(request_of(CMD_SET_MODE, 32'd10, MODE_BLINK_R, LV_NONE));
    send_request(request_of(CMD_MS_TICK, 32'd9, MODE_OFF, LV_NONE));
    send_request(request_of(CMD_MS_TICK, 32'd258, MODE_OFF, LV_NONE));
    send_request(request_of(CMD_MS_TICK, 32'd259, MODE_OFF, LV_NONE));
    send_request(request_of(CMD_SET_MODE, 32'd0, MODE_BLINK_B, LV_NONE));
    send_request(request_of(CMD_MS_TICK, 32'd250, MODE_OFF, LV_NONE));
    send_request(request_of(CMD_SET_MODE, 32'd0, MODE_BREATHE, LV_NONE));
    send_request(request_of(CMD_PWM_TICK, 32'd0, MODE_OFF, LV_NONE));
    send_request(request_of(CMD_MS_TICK, 32'hFFFF_FFFF, MODE_OFF, LV_NONE));
    send_request(request_of(CMD_DIRECT_SET, 32'hFFFF_FFFF, MODE_RESERVED, LV_ALL));
  endtask

  task automatic test_timing_extremes();
    timing_phase(16'd0, 16'd0, 30);
    timing_phase(16'hFFFF, 16'd1, 30);
    timing_phase(16'd1, 16'hFFFF, 30);
    timing_phase(16'hFFFF, 16'hFFFF, 20);
  endtask

  // Several PWM periods in a row, so the brightness steps between periods.
  task automatic test_breathe_triangle();
    int k;
    send_idle_pct = 3;
    recv_idle_pct = 3;
    send_request(request_of(CMD_SET_MODE, clock_ms, MODE_BREATHE, LV_NONE));
    for (k = 0; k < BREATHE_SWEEP; k++) begin
      send_request(request_of(CMD_PWM_TICK, $urandom,
                              3'($urandom_range(MODE_OFF, MODE_RESERVED)),
                              3'($urandom_range(LV_NONE, LV_ALL))));
    end
    send_idle_pct = IDLE_PCT_DEFAULT;
    recv_idle_pct = IDLE_PCT_DEFAULT;
  endtask

  // Results are held off for a long stretch while requests keep coming.
  task automatic test_result_backpressure();
    int k;
    send_idle_pct = 0;
    hold_results = 1'b1;
    for (k = 0; k < 24; k++) send_request(random_request());
    send_idle_pct = IDLE_PCT_DEFAULT;
  endtask

  task automatic test_random_mix();
    timing_phase(CYCLE_STEP_MS_RESET, BLINK_HALF_MS_RESET, 50);
    timing_phase(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)), 50);
    timing_phase(16'($urandom_range(1, 40)), 16'($urandom_range(1, 6)), 50);
    timing_phase(16'($urandom_range(1, 6)), 16'($urandom_range(1, 40)), 50);
  endtask

  task automatic test_quiet_tail();
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    timing_phase(16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)), 80);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_timing_extremes();
    test_breathe_triangle();
    test_result_backpressure();
    test_random_mix();
    test_quiet_tail();
    wait_idle();
    $display("Covered %0d requests across all modes and commands, %0d timing writes",
             requests_sent, timing_writes);
    $display("and a run of breathing ticks; %0d results checked, %0d LED rewrites, %0d stalls.",
             results_checked, led_rewrites, input_stalls);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
